// ----- hw/rtl/rbfos_pkg.sv -----
// ============================================================================
// rbfos_pkg
// Shared types and constants for the region box filter with overlap
// suppression: box record, cell control word, controller states, register map.
// ============================================================================
package rbfos_pkg;

    localparam int COORD_W = 10;
    localparam int COLOR_W = 8;
    localparam int GAIN_W  = 8;
    localparam int AREA_W  = 2 * COORD_W;

    // Register map indexes
    localparam logic [1:0] CFG_MIN_RATIO = 2'd0;
    localparam logic [1:0] CFG_TOP_ROW   = 2'd1;
    localparam logic [1:0] CFG_BLUE_GAIN = 2'd2;
    localparam logic [1:0] CFG_RED_GAIN  = 2'd3;

    // Input kind carried in tuser
    localparam logic CMD_BOX   = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_box;

    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_entry;

    typedef struct packed {
        logic [GAIN_W-1:0]  min_ratio;
        logic [COORD_W-1:0] top_row;
        logic [GAIN_W-1:0]  blue_gain;
        logic [GAIN_W-1:0]  red_gain;
    } t_cfg;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_KILL,
        CELL_PACK,
        CELL_APPEND,
        CELL_SHIFT
    } t_cell_op;

    // Broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op op;
        t_entry   cand;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_MATCH,
        ST_KILL,
        ST_PACK,
        ST_EMIT
    } t_state;

endpackage

// ----- hw/rtl/rbfos_screen.sv -----
// ============================================================================
// rbfos_screen
// Candidate acceptance tests (aspect ratio, bottom row, blue/red dominance)
// and candidate area, registered.
// ============================================================================
module rbfos_screen import rbfos_pkg::*; (
    input  logic              i_clk,
    input  t_box              i_cand,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_red,
    input  t_cfg              i_cfg,
    output logic              o_pass,
    output logic [AREA_W-1:0] o_area
);

    localparam int RATIO_W = COORD_W + GAIN_W;
    localparam int DOM_W   = COLOR_W + GAIN_W + 1;

    logic                r_pass;
    logic [AREA_W-1:0]   r_area;
    logic [RATIO_W-1:0]  w_mr_w;
    logic [RATIO_W-1:0]  w_mr_h;
    logic                w_ratio_ok;
    logic                w_row_ok;
    logic [DOM_W-1:0]    w_b_lhs;
    logic [DOM_W-1:0]    w_r_lhs;
    logic [DOM_W-1:0]    w_b_margin;
    logic [DOM_W-1:0]    w_r_margin;
    logic                w_blue_ok;
    logic                w_red_ok;

    // Aspect ratio strictly inside (m/256, 256/m)
    assign w_mr_w     = RATIO_W'(i_cfg.min_ratio * i_cand.w);
    assign w_mr_h     = RATIO_W'(i_cfg.min_ratio * i_cand.h);
    assign w_ratio_ok = (w_mr_w < {i_cand.h, 8'd0}) && (w_mr_h < {i_cand.w, 8'd0});

    // Bottom row below the top limit
    assign w_row_ok = ({1'b0, i_cand.y} + {1'b0, i_cand.h}) > {1'b0, i_cfg.top_row};

    // Color dominance: 256*c > 256*o + gain*c for both other channels
    assign w_b_lhs    = DOM_W'({i_blue, 8'd0});
    assign w_r_lhs    = DOM_W'({i_red, 8'd0});
    assign w_b_margin = DOM_W'(i_cfg.blue_gain * i_blue);
    assign w_r_margin = DOM_W'(i_cfg.red_gain * i_red);
    assign w_blue_ok  = (w_b_lhs > DOM_W'({i_green, 8'd0}) + w_b_margin) &&
                        (w_b_lhs > DOM_W'({i_red,   8'd0}) + w_b_margin);
    assign w_red_ok   = (w_r_lhs > DOM_W'({i_green, 8'd0}) + w_r_margin) &&
                        (w_r_lhs > DOM_W'({i_blue,  8'd0}) + w_r_margin);

    always_ff @(posedge i_clk) begin
        r_pass <= w_ratio_ok && w_row_ok && (w_blue_ok || w_red_ok);
        r_area <= AREA_W'(i_cand.w * i_cand.h);
    end

    assign o_pass = r_pass;
    assign o_area = r_area;

endmodule

// ----- hw/rtl/rbfos_cell.sv -----
// ============================================================================
// rbfos_cell
// One slot of the box store. Compares its box with the broadcast candidate,
// drops itself when suppressed, and trades contents with its neighbors to
// close gaps, take an append or shift out at frame end.
// ============================================================================
module rbfos_cell import rbfos_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_up_ent,     // from the next cell toward the tail
    input  logic      i_up_valid,
    input  logic      i_lo_valid,   // previous cell toward the head
    output t_entry    o_ent,
    output logic      o_valid,
    output logic      o_block
);

    t_entry            r_ent;
    logic              r_valid;
    logic              r_kill;
    logic              r_block;
    t_entry            n_ent;
    logic              n_valid;
    logic              w_overlap;
    logic              w_bigger;
    logic [COORD_W-1:0] w_lo_x;
    logic [COORD_W-1:0] w_lo_y;
    logic [COORD_W:0]   w_hi_x;
    logic [COORD_W:0]   w_hi_y;
    logic [COORD_W:0]   w_ca_x;
    logic [COORD_W:0]   w_ca_y;
    logic [COORD_W:0]   w_my_x;
    logic [COORD_W:0]   w_my_y;

    // Intersection of candidate with the stored box
    assign w_ca_x = {1'b0, i_ctl.cand.box.x} + {1'b0, i_ctl.cand.box.w};
    assign w_ca_y = {1'b0, i_ctl.cand.box.y} + {1'b0, i_ctl.cand.box.h};
    assign w_my_x = {1'b0, r_ent.box.x} + {1'b0, r_ent.box.w};
    assign w_my_y = {1'b0, r_ent.box.y} + {1'b0, r_ent.box.h};
    assign w_lo_x = (i_ctl.cand.box.x > r_ent.box.x) ? i_ctl.cand.box.x : r_ent.box.x;
    assign w_lo_y = (i_ctl.cand.box.y > r_ent.box.y) ? i_ctl.cand.box.y : r_ent.box.y;
    assign w_hi_x = (w_ca_x < w_my_x) ? w_ca_x : w_my_x;
    assign w_hi_y = (w_ca_y < w_my_y) ? w_ca_y : w_my_y;
    assign w_overlap = ({1'b0, w_lo_x} < w_hi_x) && ({1'b0, w_lo_y} < w_hi_y);
    assign w_bigger  = i_ctl.cand.area > r_ent.area;

    // Next slot contents
    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        unique case (i_ctl.op)
            CELL_HOLD, CELL_MATCH: begin
            end
            CELL_KILL: begin
                n_valid = r_valid && !r_kill;
            end
            CELL_PACK: begin
                // occupied slot yields to an empty slot below it
                if (r_valid) begin
                    n_valid = i_lo_valid;
                end else begin
                    n_ent   = i_up_ent;
                    n_valid = i_up_valid;
                end
            end
            CELL_APPEND: begin
                if (!r_valid && i_lo_valid) begin
                    n_ent   = i_ctl.cand;
                    n_valid = 1'b1;
                end
            end
            CELL_SHIFT: begin
                n_ent   = i_up_ent;
                n_valid = i_up_valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (i_ctl.op == CELL_MATCH) begin
            r_kill  <= r_valid && w_overlap && w_bigger;
            r_block <= r_valid && w_overlap && !w_bigger;
        end
    end

    assign o_ent   = r_ent;
    assign o_valid = r_valid;
    assign o_block = r_block;

endmodule

// ----- hw/rtl/region_box_filter_overlap_suppress.sv -----
// ============================================================================
// region_box_filter_overlap_suppress
// Screens candidate boxes, suppresses overlapping smaller boxes in a chain of
// store cells and streams the surviving boxes out at end of frame.
//
//  Channel   Direction  Content
//  s_axis    in         tdata boxes + mean colors, tuser kind (box / frame end)
//  m_axis    out        tdata kept box, tuser {store_overflow, none_kept}, tlast
//  cfg       in         write enable, 2-bit register index, 10-bit data
//
//  A candidate box passes the screen, match and kill states, then packs the
//  store, at most MAX_BOXES-1 gap-closing steps; gaps close one slot per cycle.
//  A frame end yields one output transfer per surviving box (one for an empty
//  frame); the store drains one cell per transfer.
//  Reset (synchronous, active low) empties the store and loads register
//  defaults. Output back-pressure stalls only the frame-end drain.
// ============================================================================
module region_box_filter_overlap_suppress import rbfos_pkg::*; #(
    parameter int MAX_BOXES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // box_x, box_y, box_width, box_height,
                                          // mean_blue, mean_green, mean_red
    input  logic        i_s_axis_tuser,   // cmd
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // kept_x, kept_y, kept_width, kept_height
    output logic [1:0]  o_m_axis_tuser,   // none_kept, store_overflow
    output logic        o_m_axis_tlast,   // last_box
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);

    t_state             r_state;
    t_state             n_state;
    t_cfg               r_cfg;
    t_box               r_cand;
    logic [COLOR_W-1:0] r_blue;
    logic [COLOR_W-1:0] r_green;
    logic [COLOR_W-1:0] r_red;
    logic               r_add;
    logic               r_ovf;
    logic               r_emit_ovf;
    logic               r_out_valid;
    t_box               r_out_box;
    logic               r_out_none;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               w_pass;
    logic [AREA_W-1:0]  w_area;
    t_cell_ctl          w_ctl;
    t_entry             w_ent     [MAX_BOXES];
    t_entry             w_nb_ent  [MAX_BOXES];
    logic [MAX_BOXES-1:0] w_valid;
    logic [MAX_BOXES-1:0] w_block;
    logic [MAX_BOXES-1:0] w_nb_valid;
    logic [MAX_BOXES-1:0] w_lo_valid;
    logic               w_hole;
    logic               w_full;
    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_emit;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_emit          = (r_state == ST_EMIT) && w_out_free;
    assign w_full          = w_valid[MAX_BOXES-1];

    // Any occupied slot above an empty one
    always_comb begin
        w_hole = 1'b0;
        for (int i = 1; i < MAX_BOXES; i++) begin
            w_hole = w_hole | (w_valid[i] & ~w_valid[i-1]);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ratio <= 8'd128;
            r_cfg.top_row   <= 10'd0;
            r_cfg.blue_gain <= 8'd64;
            r_cfg.red_gain  <= 8'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_RATIO: r_cfg.min_ratio <= i_cfg_wdata[GAIN_W-1:0];
                CFG_TOP_ROW:   r_cfg.top_row   <= i_cfg_wdata;
                CFG_BLUE_GAIN: r_cfg.blue_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_RED_GAIN:  r_cfg.red_gain  <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Candidate capture
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cand.x <= i_s_axis_tdata[9:0];
            r_cand.y <= i_s_axis_tdata[19:10];
            r_cand.w <= i_s_axis_tdata[29:20];
            r_cand.h <= i_s_axis_tdata[39:30];
            r_blue   <= i_s_axis_tdata[47:40];
            r_green  <= i_s_axis_tdata[55:48];
            r_red    <= i_s_axis_tdata[63:56];
        end
    end

    rbfos_screen u_screen (
        .i_clk   (i_clk),
        .i_cand  (r_cand),
        .i_blue  (r_blue),
        .i_green (r_green),
        .i_red   (r_red),
        .i_cfg   (r_cfg),
        .o_pass  (w_pass),
        .o_area  (w_area)
    );

    // Store cells
    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
        if (i == MAX_BOXES - 1) begin : g_tail
            assign w_nb_ent[i]   = '0;
            assign w_nb_valid[i] = 1'b0;
        end else begin : g_body
            assign w_nb_ent[i]   = w_ent[i+1];
            assign w_nb_valid[i] = w_valid[i+1];
        end
        if (i == 0) begin : g_head
            assign w_lo_valid[i] = 1'b1;
        end else begin : g_rest
            assign w_lo_valid[i] = w_valid[i-1];
        end

        rbfos_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_up_ent   (w_nb_ent[i]),
            .i_up_valid (w_nb_valid[i]),
            .i_lo_valid (w_lo_valid[i]),
            .o_ent      (w_ent[i]),
            .o_valid    (w_valid[i]),
            .o_block    (w_block[i])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_s_axis_tuser == CMD_FRAME) ? ST_EMIT : ST_SCREEN;
                end
            end
            ST_SCREEN: n_state = ST_MATCH;
            ST_MATCH:  n_state = ST_KILL;
            ST_KILL:   n_state = ST_PACK;
            ST_PACK: begin
                if (!w_hole) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_free && !(w_valid[0] && w_nb_valid[0])) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Cell commands
    always_comb begin
        w_ctl.cand.box  = r_cand;
        w_ctl.cand.area = w_area;
        w_ctl.op        = CELL_HOLD;
        unique case (r_state)
            ST_IDLE, ST_SCREEN: w_ctl.op = CELL_HOLD;
            ST_MATCH:           w_ctl.op = CELL_MATCH;
            ST_KILL:            w_ctl.op = w_pass ? CELL_KILL : CELL_HOLD;
            ST_PACK: begin
                if (w_hole) begin
                    w_ctl.op = CELL_PACK;
                end else if (r_add && !w_full) begin
                    w_ctl.op = CELL_APPEND;
                end
            end
            ST_EMIT: begin
                if (w_out_free && w_valid[0]) begin
                    w_ctl.op = CELL_SHIFT;
                end
            end
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer && i_s_axis_tuser == CMD_FRAME) begin
                r_ovf <= 1'b0;
            end else if (r_state == ST_PACK && !w_hole && r_add && w_full) begin
                r_ovf <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Append decision and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_KILL) begin
            r_add <= w_pass && !(|w_block);
        end
        if (w_in_xfer) begin
            r_emit_ovf <= r_ovf;
        end
        if (w_emit) begin
            r_out_ovf <= r_emit_ovf;
            if (w_valid[0]) begin
                r_out_box  <= w_ent[0].box;
                r_out_none <= 1'b0;
                r_out_last <= !w_nb_valid[0];
            end else begin
                r_out_box  <= '0;
                r_out_none <= 1'b1;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_box.h, r_out_box.w, r_out_box.y, r_out_box.x};
    assign o_m_axis_tuser  = {r_out_ovf, r_out_none};
    assign o_m_axis_tlast  = r_out_last;

    // Store is compact whenever the block waits for input
    a_packed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_hole)
        else $error("store has a gap while idle");

    // Overflow only raised with a full store
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> w_full)
        else $error("overflow flagged with free slot");

    // Empty-frame result carries zero box and ends the frame
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |-> (r_out_last && r_out_box == '0))
        else $error("empty-frame result malformed");

    // Compare stage always follows screening
    a_match_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MATCH) |-> ($past(r_state) == ST_SCREEN))
        else $error("match entered out of order");

endmodule
